// ----- design/slqt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slqt_pkg - shared types and constants of the sprite layer quad transform
// Holds field widths, the quarter-wave sine table and the carried item fields.
// ----------------------------------------------------------------------------
package slqt_pkg;

    // Field widths
    localparam int DimW    = 10;
    localparam int ScaleW  = 16;
    localparam int AngleW  = 9;
    localparam int ShiftW  = 16;
    localparam int ColorW  = 32;
    localparam int CornerW = 27;
    localparam int TrigW   = 16;
    localparam int PosW    = 11;
    localparam int CtrW    = 17;
    localparam int DeltaW  = 28;
    localparam int ProdW   = DeltaW + TrigW;
    localparam int SumW    = 46;
    localparam int FracDrop = 19;

    localparam logic [AngleW-1:0] DegFull    = 9'd360;
    localparam logic [AngleW-1:0] DegHalf    = 9'd180;
    localparam logic [AngleW-1:0] DegQuarter = 9'd90;
    localparam logic [AngleW-1:0] DegThreeQ  = 9'd270;
    localparam logic [ColorW-1:0] ColorWhite = 32'hFFFF_FFFF;

    // Sine over 0..90 degrees, Q1.14
    localparam logic [14:0] SINE_QUARTER [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    // Fields that ride along the pipeline untouched until the last stage
    typedef struct packed {
        logic                     empty;
        logic                     flip;
        logic [ColorW-1:0]        color;
        logic signed [ShiftW-1:0] offx;
        logic signed [ShiftW-1:0] offy;
    } meta_t;

    // Sine of a whole degree in 0..359, Q1.14
    function automatic logic signed [TrigW-1:0] sine_deg(input logic [AngleW-1:0] d);
        logic [AngleW-1:0] idx;
        logic              neg;
        logic [TrigW-1:0]  mag;
        begin
            if (d <= DegQuarter) begin
                idx = d;
                neg = 1'b0;
            end else if (d <= DegHalf) begin
                idx = DegHalf - d;
                neg = 1'b0;
            end else if (d <= DegThreeQ) begin
                idx = d - DegHalf;
                neg = 1'b1;
            end else begin
                idx = DegFull - d;
                neg = 1'b1;
            end
            mag = {1'b0, SINE_QUARTER[idx[6:0]]};
            sine_deg = neg ? -$signed(mag) : $signed(mag);
        end
    endfunction

endpackage

// ----- design/sprite_layer_quad_transform.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_layer_quad_transform - affine corners of one sprite layer
// Centres, scales, rotates and shifts the image quad; repacks the tint.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one sprite layer per transfer;
//   output channel out_valid/out_stall returns its four corners (TL, TR, BR,
//   BL, signed Q18.8), the mirror flag and the ABGR tint.
//   cfg_we/cfg_data write rotation_enable; write it only while idle.
//   One layer is taken every cycle unless a stalled result holds the pipeline;
//   the rate is set by the five-stage pipeline, whose stages are angle lookup,
//   scale multiply, trig multiply, sum, round.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_stall rises; nothing is dropped or repeated.
//   Reset clears all valid bits and sets rotation_enable to one.
//   An empty image gives layer_ok low and every other field zero.
// ----------------------------------------------------------------------------
module sprite_layer_quad_transform (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [9:0]          img_width,
    input  logic [9:0]          img_height,
    input  logic signed [15:0]  scale_horiz,
    input  logic signed [15:0]  scale_vert,
    input  logic [8:0]          angle_deg,
    input  logic signed [15:0]  shift_x,
    input  logic signed [15:0]  shift_y,
    input  logic                flip_u,
    input  logic [31:0]         color_argb,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                layer_ok,
    output logic signed [26:0]  tl_x,
    output logic signed [26:0]  tl_y,
    output logic signed [26:0]  tr_x,
    output logic signed [26:0]  tr_y,
    output logic signed [26:0]  br_x,
    output logic signed [26:0]  br_y,
    output logic signed [26:0]  bl_x,
    output logic signed [26:0]  bl_y,
    output logic                u_swapped,
    output logic [31:0]         color_abgr
);

    logic rot_en_reg;
    logic adv;
    logic [4:0] vld_reg;

    // Stage 1 registers
    slqt_pkg::meta_t                          m1_reg;
    logic signed [slqt_pkg::PosW-1:0]         x0_reg, x1_reg, y0_reg, y1_reg;
    logic signed [slqt_pkg::ScaleW-1:0]       sclx_reg, scly_reg;
    logic signed [slqt_pkg::TrigW-1:0]        sin1_reg, cos1_reg;
    logic signed [slqt_pkg::CtrW-1:0]         cx1_reg, cy1_reg;
    // Stage 2 registers
    slqt_pkg::meta_t                          m2_reg;
    logic signed [slqt_pkg::DeltaW-1:0]       dx0_reg, dx1_reg, dy0_reg, dy1_reg;
    logic signed [slqt_pkg::TrigW-1:0]        sin2_reg, cos2_reg;
    logic signed [slqt_pkg::CtrW-1:0]         cx2_reg, cy2_reg;
    // Stage 3 registers
    slqt_pkg::meta_t                          m3_reg;
    logic signed [slqt_pkg::ProdW-1:0]        pxc0_reg, pxc1_reg, pxs0_reg, pxs1_reg;
    logic signed [slqt_pkg::ProdW-1:0]        pyc0_reg, pyc1_reg, pys0_reg, pys1_reg;
    logic signed [slqt_pkg::CtrW-1:0]         cx3_reg, cy3_reg;
    // Stage 4 registers
    slqt_pkg::meta_t                          m4_reg;
    logic signed [slqt_pkg::SumW-1:0]         rx_reg [4];
    logic signed [slqt_pkg::SumW-1:0]         ry_reg [4];
    // Stage 5 (output) registers
    slqt_pkg::meta_t                          m5_reg;
    logic signed [slqt_pkg::CornerW-1:0]      qx_reg [4];
    logic signed [slqt_pkg::CornerW-1:0]      qy_reg [4];

    // Stage 1 next values
    logic [slqt_pkg::AngleW-1:0]              deg_n, cdeg_sum, cdeg_n;
    logic                                     rot_n;
    logic [slqt_pkg::DimW-1:0]                halfw_n, halfh_n;
    logic signed [slqt_pkg::PosW-1:0]         x0_next, y0_next;
    slqt_pkg::meta_t                          m1_next;

    // Stage 2/4/5 helpers
    logic signed [26:0]                       ax0, ax1, ay0, ay1;
    logic signed [slqt_pkg::SumW-1:0]         cxs, cys;
    logic signed [slqt_pkg::SumW-1:0]         rx_next [4];
    logic signed [slqt_pkg::SumW-1:0]         ry_next [4];
    logic signed [slqt_pkg::CornerW-1:0]      qx_next [4];
    logic signed [slqt_pkg::CornerW-1:0]      qy_next [4];
    logic signed [slqt_pkg::SumW-1:0]         tx, ty;
    logic signed [slqt_pkg::CornerW-1:0]      ox, oy;

    // Advance everything unless a finished result is held up
    assign adv      = !(vld_reg[4] && out_stall);
    assign in_stall = !adv;

    // Hold the rotation switch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rot_en_reg <= 1'b1;
        else if (cfg_we)
            rot_en_reg <= cfg_data;
    end

    // Move the valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    // Stage 1: reduce angle, look up trig, place the quad
    always_comb
    begin
        deg_n    = (angle_deg >= slqt_pkg::DegFull) ? angle_deg - slqt_pkg::DegFull
                                                    : angle_deg;
        cdeg_sum = deg_n + slqt_pkg::DegQuarter;
        cdeg_n   = (cdeg_sum >= slqt_pkg::DegFull) ? cdeg_sum - slqt_pkg::DegFull
                                                   : cdeg_sum;
        rot_n    = rot_en_reg && (deg_n != '0);
        halfw_n  = 10'(({1'b0, img_width} + 11'd1) >> 1);
        halfh_n  = 10'(({1'b0, img_height} + 11'd1) >> 1);
        x0_next  = -$signed({1'b0, halfw_n});
        y0_next  = -$signed({1'b0, halfh_n});
        m1_next.empty = (img_width == '0) || (img_height == '0);
        m1_next.flip  = flip_u;
        m1_next.color = color_argb;
        m1_next.offx  = shift_x;
        m1_next.offy  = shift_y;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg   <= m1_next;
            x0_reg   <= x0_next;
            x1_reg   <= x0_next + $signed({1'b0, img_width});
            y0_reg   <= y0_next;
            y1_reg   <= y0_next + $signed({1'b0, img_height});
            sclx_reg <= scale_horiz;
            scly_reg <= scale_vert;
            sin1_reg <= rot_n ? slqt_pkg::sine_deg(deg_n) : 16'sd0;
            cos1_reg <= rot_n ? slqt_pkg::sine_deg(cdeg_n) : 16'sd16384;
            cx1_reg  <= (rot_n && img_width[0])  ? -17'(scale_horiz) : 17'sd0;
            cy1_reg  <= (rot_n && img_height[0]) ? -17'(scale_vert)  : 17'sd0;
        end
    end

    // Stage 2: scale corners to Q13 about the rotation centre
    assign ax0 = x0_reg * sclx_reg;
    assign ax1 = x1_reg * sclx_reg;
    assign ay0 = y0_reg * scly_reg;
    assign ay1 = y1_reg * scly_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_reg   <= m1_reg;
            dx0_reg  <= {ax0, 1'b0} - 28'(cx1_reg);
            dx1_reg  <= {ax1, 1'b0} - 28'(cx1_reg);
            dy0_reg  <= {ay0, 1'b0} - 28'(cy1_reg);
            dy1_reg  <= {ay1, 1'b0} - 28'(cy1_reg);
            sin2_reg <= sin1_reg;
            cos2_reg <= cos1_reg;
            cx2_reg  <= cx1_reg;
            cy2_reg  <= cy1_reg;
        end
    end

    // Stage 3: trig products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_reg   <= m2_reg;
            pxc0_reg <= dx0_reg * cos2_reg;
            pxc1_reg <= dx1_reg * cos2_reg;
            pxs0_reg <= dx0_reg * sin2_reg;
            pxs1_reg <= dx1_reg * sin2_reg;
            pyc0_reg <= dy0_reg * cos2_reg;
            pyc1_reg <= dy1_reg * cos2_reg;
            pys0_reg <= dy0_reg * sin2_reg;
            pys1_reg <= dy1_reg * sin2_reg;
            cx3_reg  <= cx2_reg;
            cy3_reg  <= cy2_reg;
        end
    end

    // Stage 4: sum each corner in Q27, order TL, TR, BR, BL
    always_comb
    begin
        cxs = {{15{cx3_reg[16]}}, cx3_reg, 14'b0};
        cys = {{15{cy3_reg[16]}}, cy3_reg, 14'b0};
        rx_next[0] = cxs + 46'(pxc0_reg) - 46'(pys0_reg);
        ry_next[0] = cys + 46'(pxs0_reg) + 46'(pyc0_reg);
        rx_next[1] = cxs + 46'(pxc1_reg) - 46'(pys0_reg);
        ry_next[1] = cys + 46'(pxs1_reg) + 46'(pyc0_reg);
        rx_next[2] = cxs + 46'(pxc1_reg) - 46'(pys1_reg);
        ry_next[2] = cys + 46'(pxs1_reg) + 46'(pyc1_reg);
        rx_next[3] = cxs + 46'(pxc0_reg) - 46'(pys1_reg);
        ry_next[3] = cys + 46'(pxs0_reg) + 46'(pyc1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m4_reg <= m3_reg;
            for (int k = 0; k < 4; k++)
            begin
                rx_reg[k] <= rx_next[k];
                ry_reg[k] <= ry_next[k];
            end
        end
    end

    // Stage 5: round half up to Q8, add the offset, blank empty layers
    always_comb
    begin
        ox = {{3{m4_reg.offx[15]}}, m4_reg.offx, 8'b0};
        oy = {{3{m4_reg.offy[15]}}, m4_reg.offy, 8'b0};
        tx = '0;
        ty = '0;
        for (int k = 0; k < 4; k++)
        begin
            tx = rx_reg[k] + 46'sd262144;
            ty = ry_reg[k] + 46'sd262144;
            qx_next[k] = m4_reg.empty ? '0 : tx[45:19] + ox;
            qy_next[k] = m4_reg.empty ? '0 : ty[45:19] + oy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m5_reg <= m4_reg;
            for (int k = 0; k < 4; k++)
            begin
                qx_reg[k] <= qx_next[k];
                qy_reg[k] <= qy_next[k];
            end
        end
    end

    // Drive the result ports
    assign out_valid  = vld_reg[4];
    assign layer_ok   = !m5_reg.empty;
    assign tl_x       = qx_reg[0];
    assign tl_y       = qy_reg[0];
    assign tr_x       = qx_reg[1];
    assign tr_y       = qy_reg[1];
    assign br_x       = qx_reg[2];
    assign br_y       = qy_reg[2];
    assign bl_x       = qx_reg[3];
    assign bl_y       = qy_reg[3];
    assign u_swapped  = m5_reg.empty ? 1'b0 : m5_reg.flip;
    assign color_abgr = m5_reg.empty ? '0
                      : (m5_reg.color == '0) ? slqt_pkg::ColorWhite
                      : {m5_reg.color[31:24], m5_reg.color[7:0],
                         m5_reg.color[15:8], m5_reg.color[23:16]};

endmodule

// ----- dv/slqt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slqt_checker - corner and tint predictor for the sprite layer transform
// Watches both channels, computes the expected quad for each input transfer
// and compares every output transfer against the oldest pending quad.
// ----------------------------------------------------------------------------
module slqt_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [9:0]         img_width,
    input  logic [9:0]         img_height,
    input  logic signed [15:0] scale_horiz,
    input  logic signed [15:0] scale_vert,
    input  logic [8:0]         angle_deg,
    input  logic signed [15:0] shift_x,
    input  logic signed [15:0] shift_y,
    input  logic               flip_u,
    input  logic [31:0]        color_argb,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               layer_ok,
    input  logic [26:0]        tl_x,
    input  logic [26:0]        tl_y,
    input  logic [26:0]        tr_x,
    input  logic [26:0]        tr_y,
    input  logic [26:0]        br_x,
    input  logic [26:0]        br_y,
    input  logic [26:0]        bl_x,
    input  logic [26:0]        bl_y,
    input  logic               u_swapped,
    input  logic [31:0]        color_abgr,
    output int                 fail_count,
    output int                 pending_quads
);

    typedef struct packed {
        logic        ok;
        logic [26:0] cx0, cy0, cx1, cy1, cx2, cy2, cx3, cy3;
        logic        swap;
        logic [31:0] abgr;
    } quad_t;

    localparam int FifoDepth = 64;

    quad_t quad_fifo [FifoDepth];
    int    wr_ptr;
    int    rd_ptr;
    logic  rot_on;

    // Quarter-wave sine in Q1.14 for whole degrees 0..359
    function automatic longint trig_sine(input int d);
        int q [0:90] = '{
            0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
            2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
            5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
            8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
            10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
            12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
            14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
            15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
            16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
            16384};
        if (d <= 90) return q[d];
        if (d <= 180) return q[180 - d];
        if (d <= 270) return -q[d - 180];
        return -q[(360 - d) % 91];
    endfunction

    // Work out the corners, flag and tint of one layer
    function automatic quad_t transform_layer(
        input logic [9:0] w, input logic [9:0] h,
        input logic signed [15:0] sx, input logic signed [15:0] sy,
        input logic [8:0] ang, input logic signed [15:0] ox,
        input logic signed [15:0] oy, input logic fl, input logic [31:0] c,
        input logic ren);
        quad_t  r;
        int     d;
        longint left, top, cs, sn, ctx, cty, dx, dy, rx, ry;
        longint xs[4], ys[4];
        logic [63:0] qx, qy;
        r = '0;
        if (w == 0 || h == 0) return r;
        d = ang;
        if (d >= 360) d -= 360;
        left = -longint'((w + 1) / 2);
        top = -longint'((h + 1) / 2);
        xs[0] = left;     ys[0] = top;
        xs[1] = left + w; ys[1] = top;
        xs[2] = left + w; ys[2] = top + h;
        xs[3] = left;     ys[3] = top + h;
        cs = 16384; sn = 0; ctx = 0; cty = 0;
        if (ren && d != 0)
        begin
            sn = trig_sine(d);
            cs = trig_sine((d + 90) % 360);
            ctx = w[0] ? -longint'(sx) : 0;
            cty = h[0] ? -longint'(sy) : 0;
        end
        for (int k = 0; k < 4; k++)
        begin
            dx = 2 * xs[k] * sx - ctx;
            dy = 2 * ys[k] * sy - cty;
            rx = ctx * 16384 + dx * cs - dy * sn;
            ry = cty * 16384 + dx * sn + dy * cs;
            // round half up from Q27 to Q8 by arithmetic shift
            qx = ((rx + (64'sd1 <<< 18)) >>> 19) + (longint'(ox) <<< 8);
            qy = ((ry + (64'sd1 <<< 18)) >>> 19) + (longint'(oy) <<< 8);
            case (k)
                0:
                begin
                    r.cx0 = qx[26:0]; r.cy0 = qy[26:0];
                end
                1:
                begin
                    r.cx1 = qx[26:0]; r.cy1 = qy[26:0];
                end
                2:
                begin
                    r.cx2 = qx[26:0]; r.cy2 = qy[26:0];
                end
                default:
                begin
                    r.cx3 = qx[26:0]; r.cy3 = qy[26:0];
                end
            endcase
        end
        r.ok = 1'b1;
        r.swap = fl;
        r.abgr = (c == 0) ? 32'hFFFF_FFFF : {c[31:24], c[7:0], c[15:8], c[23:16]};
        return r;
    endfunction

    // Track the register, queue predictions, compare transfers
    always @(posedge clk or negedge rst_n)
    begin
        quad_t want, got;
        if (!rst_n)
        begin
            rot_on <= 1'b1;
            wr_ptr = 0;
            rd_ptr = 0;
            fail_count <= 0;
            pending_quads <= 0;
        end
        else
        begin
            if (cfg_we) rot_on <= cfg_data;
            if (in_valid && !in_stall)
            begin
                quad_fifo[wr_ptr % FifoDepth] = transform_layer(img_width, img_height,
                    scale_horiz, scale_vert, angle_deg, shift_x, shift_y,
                    flip_u, color_argb, rot_on);
                wr_ptr = wr_ptr + 1;
            end
            if (out_valid && !out_stall)
            begin
                got = {layer_ok, tl_x, tl_y, tr_x, tr_y, br_x, br_y, bl_x, bl_y,
                       u_swapped, color_abgr};
                if (wr_ptr == rd_ptr)
                begin
                    if (fail_count < 10) $display("unexpected output transfer %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = quad_fifo[rd_ptr % FifoDepth];
                    rd_ptr = rd_ptr + 1;
                    if (want !== got)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %h got %h", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_quads <= wr_ptr - rd_ptr;
        end
    end
endmodule

// ----- dv/tb_sprite_layer_quad_transform.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_layer_quad_transform - regression for the sprite layer transform
// Drives directed and random layers with random gaps and stalls, switches
// the rotation register between phases and reports the checker verdict.
// ----------------------------------------------------------------------------
module tb_sprite_layer_quad_transform;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0, cfg_data = 1'b0;
    logic               in_valid = 1'b0, out_stall = 1'b0;
    logic               in_stall, out_valid;
    logic [9:0]         img_width = '0, img_height = '0;
    logic signed [15:0] scale_horiz = '0, scale_vert = '0;
    logic [8:0]         angle_deg = '0;
    logic signed [15:0] shift_x = '0, shift_y = '0;
    logic               flip_u = 1'b0;
    logic [31:0]        color_argb = '0;
    logic               layer_ok, u_swapped;
    logic [26:0]        tl_x, tl_y, tr_x, tr_y, br_x, br_y, bl_x, bl_y;
    logic [31:0]        color_abgr;
    int                 fail_count, pending_quads, quiet_cycles;
    logic               calm;

    localparam int WatchdogLimit = 2000;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sprite_layer_quad_transform uut (.*);

    slqt_checker checker_i (.*);

    // Random receiver stalls, with a calm stretch
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 27);

    // Stop the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one layer and hold it until the transfer happens
    task automatic send_layer(input logic [9:0] w, input logic [9:0] h,
                              input logic [15:0] sx, input logic [15:0] sy,
                              input logic [8:0] a, input logic [15:0] ox,
                              input logic [15:0] oy, input logic f,
                              input logic [31:0] c);
        while (!calm && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        img_width <= w; img_height <= h; scale_horiz <= sx; scale_vert <= sy;
        angle_deg <= a; shift_x <= ox; shift_y <= oy; flip_u <= f;
        color_argb <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_quads != 0 || out_valid) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_rotation(input logic v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_layers(input int n);
        logic [9:0] w, h;
        for (int i = 0; i < n; i++)
        begin
            calm = (i >= n / 3 && i < n / 2);
            // mostly small sizes, a few of any size, zero included
            w = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(1, 64));
            h = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(1, 64));
            send_layer(w, h, 16'($urandom), 16'($urandom),
                       9'($urandom_range(($urandom_range(19) == 0) ? 511 : 359)),
                       16'($urandom), 16'($urandom), 1'($urandom),
                       ($urandom_range(15) == 0) ? 32'd0 : $urandom);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        calm = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, empty images, zero tint, each quadrant
        send_layer(10'd0, 10'd5, 16'h1000, 16'h1000, 9'd30, 16'd0, 16'd0, 1'b1, 32'h1234_5678);
        send_layer(10'd5, 10'd0, 16'h1000, 16'h1000, 9'd30, 16'd0, 16'd0, 1'b0, 32'h0);
        send_layer(10'd1, 10'd1, 16'h1000, 16'h1000, 9'd0, 16'd0, 16'd0, 1'b0, 32'h0);
        send_layer(10'd1023, 10'd1023, 16'h7FFF, 16'h8000, 9'd45, 16'h7FFF,
                   16'h8000, 1'b1, 32'hFFFF_FFFF);
        send_layer(10'd1023, 10'd1022, 16'h8000, 16'h7FFF, 9'd359, 16'h8000,
                   16'h7FFF, 1'b0, 32'hAABB_CCDD);
        send_layer(10'd3, 10'd4, 16'h0800, 16'hF000, 9'd90, 16'd10, -16'sd10, 1'b0, 32'h1);
        send_layer(10'd7, 10'd9, 16'h2000, 16'h1000, 9'd180, 16'd0, 16'd3, 1'b1, 32'h8000_0000);
        send_layer(10'd8, 10'd6, 16'h1000, 16'h3000, 9'd270, -16'sd1, 16'd0, 1'b0, 32'h00FF_0000);
        send_layer(10'd33, 10'd17, 16'h1800, 16'h0400, 9'd135, 16'd5, 16'd5, 1'b0, 32'h0000_FF00);
        send_layer(10'd12, 10'd13, 16'h1000, 16'h1000, 9'd360, 16'd0, 16'd0, 1'b0, 32'h55AA_55AA);
        send_layer(10'd12, 10'd13, 16'h1000, 16'h1000, 9'd511, 16'd0, 16'd0, 1'b1, 32'h0102_0304);
        send_layer(10'd513, 10'd2, 16'h0000, 16'hFFFF, 9'd225, 16'd100, 16'd1, 1'b0, 32'h0000_00FF);
        drain_pipe();
        random_layers(400);
        drain_pipe();
        // rotation off phase
        set_rotation(1'b0);
        send_layer(10'd1023, 10'd1023, 16'h7FFF, 16'h8000, 9'd45, 16'h7FFF,
                   16'h8000, 1'b1, 32'hFFFF_FFFF);
        random_layers(300);
        drain_pipe();
        set_rotation(1'b1);
        random_layers(500);
        drain_pipe();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
